// ----- rtl/core/fbfl_pkg.sv -----
// Shared types and constants of the fixed block free list allocator.
package fbfl_pkg;

    // Register indexes of the configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

    // Request kinds.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Response status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OOM     = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    // Smallest block size honored; smaller settings behave as this one.
    localparam logic [12:0] MIN_BLOCK_SIZE = 13'd8;

    // Number of entries in the link memory. The step counts of the shared unit below are
    // sized for this depth.
    localparam int MAX_BLOCKS = 256;

    // A block index never exceeds eight bits since the count is at most 256.
    // The divider produces one extra quotient bit that flags an out-of-range offset.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] MUL_LAST_STEP = 4'd7;
    localparam logic [STEP_W-1:0] DIV_TOP_STEP  = 4'd8;

    typedef enum logic [2:0] {
        AOP_IDLE,
        AOP_LOAD_MUL,
        AOP_MUL_STEP,
        AOP_ADD_BASE,
        AOP_LOAD_OFF,
        AOP_DIV_STEP
    } arith_op_t;

    typedef struct packed {
        arith_op_t          op;
        logic [STEP_W-1:0]  step;
    } arith_cmd_t;

    typedef struct packed {
        logic        action;
        logic [31:0] block_address;
    } req_word_t;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [1:0]  status;
    } rsp_word_t;

endpackage

// ----- rtl/core/fbfl_link_ram.sv -----
// Next-link memory of the free list: one write port, one registered read port.
module fbfl_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/fbfl_arith.sv -----
// Shared add/subtract unit with accumulator for shift-add multiply and restoring divide.
module fbfl_arith (
    input  logic                  clk,
    input  fbfl_pkg::arith_cmd_t  cmd,
    input  logic [31:0]           pool_base,
    input  logic [12:0]           block_size,
    input  logic [31:0]           block_address,
    input  logic [7:0]            block_index,
    output logic [31:0]           acc,
    output logic [8:0]            quotient
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [8:0]  aux_reg;
    logic [8:0]  aux_next;
    logic [31:0] size_sh;
    logic [31:0] opa;
    logic [31:0] opb;
    logic        sub;
    logic [32:0] sum;

    always_comb
    begin
        size_sh = {19'd0, block_size} << cmd.step;
        opa     = acc_reg;
        opb     = size_sh;
        sub     = 1'b0;
        case (cmd.op)
            fbfl_pkg::AOP_ADD_BASE:
            begin
                opb = pool_base;
            end
            fbfl_pkg::AOP_LOAD_OFF:
            begin
                opa = block_address;
                opb = pool_base;
                sub = 1'b1;
            end
            fbfl_pkg::AOP_DIV_STEP:
            begin
                sub = 1'b1;
            end
            default:
            begin
            end
        endcase

        // On subtract the carry out is set exactly when opa >= opb.
        sum = {1'b0, opa} + {1'b0, opb ^ {32{sub}}} + 33'(sub);

        acc_next = acc_reg;
        aux_next = aux_reg;
        case (cmd.op)
            fbfl_pkg::AOP_LOAD_MUL:
            begin
                acc_next = '0;
                aux_next = {1'b0, block_index};
            end
            fbfl_pkg::AOP_MUL_STEP:
            begin
                if (aux_reg[cmd.step])
                begin
                    acc_next = sum[31:0];
                end
            end
            fbfl_pkg::AOP_ADD_BASE:
            begin
                acc_next = sum[31:0];
            end
            fbfl_pkg::AOP_LOAD_OFF:
            begin
                acc_next = sum[31:0];
                aux_next = '0;
            end
            fbfl_pkg::AOP_DIV_STEP:
            begin
                if (sum[32])
                begin
                    acc_next = sum[31:0];
                end
                aux_next[cmd.step] = sum[32];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        aux_reg <= aux_next;
    end

    assign acc      = acc_reg;
    assign quotient = aux_reg;

endmodule

// ----- rtl/core/fixed_block_free_list_allocator.sv -----
// Top level of the fixed block free list allocator: sequencer, config registers, free list head.
//
//  Channel | Signals                                   | Moves
//  --------+-------------------------------------------+-------------------------------------
//  req     | req_valid, req_ready, req_data            | one allocate or free request word
//  rsp     | rsp_valid, rsp_ready, rsp_data            | one response word per finished request
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write word
//
// An allocate forms index * block_size in 8 shift-add steps of the shared adder; one more adds
// the pool base. A free forms the offset with one subtract, and 9 restoring divide steps on the
// same adder give the block index, the range flag and the remainder. An allocate on an empty
// list goes straight to its OOM response. No request is accepted until the response to the last
// one is registered. After reset, and after every write to a defined register, which abandons
// any request in progress, the link memory is rebuilt by a sweep over all MAX_BLOCKS entries,
// one entry per cycle, during which no request is accepted. A full response register that is
// not taken holds the sequencer in its final state; the configuration port is always ready.
module fixed_block_free_list_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  fbfl_pkg::req_word_t              req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output fbfl_pkg::rsp_word_t              rsp_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int IDX_W  = (fbfl_pkg::MAX_BLOCKS > 1) ? $clog2(fbfl_pkg::MAX_BLOCKS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam logic [16:0]      MAX_B17  = 17'(fbfl_pkg::MAX_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(fbfl_pkg::MAX_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MUL,
        S_BASE,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [IDX_W-1:0]            sweep_idx_reg;
    logic [IDX_W-1:0]            head_reg;
    logic                        head_valid_reg;
    logic [fbfl_pkg::STEP_W-1:0] step_reg;
    logic                        act_reg;
    logic                        oom_reg;
    logic                        rsp_valid_reg;
    fbfl_pkg::rsp_word_t         rsp_data_reg;

    logic [31:0] pool_base_reg;
    logic [12:0] block_size_reg;
    logic [8:0]  block_count_reg;

    logic [12:0] eff_size;
    logic [8:0]  eff_count;
    logic [16:0] count_m1;
    logic        req_fire;
    logic        done_fire;
    logic        cfg_hit;
    logic        free_ok;

    fbfl_pkg::arith_cmd_t arith_cmd;
    logic [31:0]          acc;
    logic [8:0]           quotient;
    logic [IDX_W+7:0]     head_ext;
    logic [IDX_W+8:0]     quot_ext;
    logic [IDX_W-1:0]     free_idx;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [LINK_W-1:0] rd_data;
    logic              sweep_link_valid;

    // Out-of-range settings are clamped exactly as the allocator defines them.
    assign eff_size  = (block_size_reg < fbfl_pkg::MIN_BLOCK_SIZE) ?
                       fbfl_pkg::MIN_BLOCK_SIZE : block_size_reg;
    assign eff_count = (17'(block_count_reg) > MAX_B17) ? MAX_B17[8:0] : block_count_reg;
    assign count_m1  = 17'(eff_count) - 17'd1;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign done_fire = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == fbfl_pkg::REG_POOL_BASE) ||
                                     (cfg_index == fbfl_pkg::REG_BLOCK_SIZE) ||
                                     (cfg_index == fbfl_pkg::REG_BLOCK_COUNT));

    // Block indexes stay below 256, so the multiplier input is the low eight bits of the head.
    assign head_ext = {8'd0, head_reg};
    assign quot_ext = {IDX_W'(0), quotient};
    assign free_idx = quot_ext[IDX_W-1:0];

    // A freed address is good when its quotient is below the block count (the range flag in
    // the top quotient bit makes that fail on its own) and nothing is left over.
    assign free_ok = (quotient < eff_count) && (acc == 32'd0);

    // Sequencer commands for the shared unit.
    always_comb
    begin
        arith_cmd.op   = fbfl_pkg::AOP_IDLE;
        arith_cmd.step = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_data.action == fbfl_pkg::ACT_FREE)
                    begin
                        arith_cmd.op = fbfl_pkg::AOP_LOAD_OFF;
                    end
                    else if (head_valid_reg)
                    begin
                        arith_cmd.op = fbfl_pkg::AOP_LOAD_MUL;
                    end
                end
            end
            S_MUL:
            begin
                arith_cmd.op = fbfl_pkg::AOP_MUL_STEP;
            end
            S_BASE:
            begin
                arith_cmd.op = fbfl_pkg::AOP_ADD_BASE;
            end
            S_DIV:
            begin
                arith_cmd.op = fbfl_pkg::AOP_DIV_STEP;
            end
            default:
            begin
            end
        endcase
    end

    // Link memory access. The sweep writes block i -> i-1, valid when 0 < i < count.
    // The head's link is read at acceptance and consumed when the allocate completes.
    assign sweep_link_valid = (sweep_idx_reg != '0) &&
                              (17'(sweep_idx_reg) < 17'(eff_count));
    assign rd_en = req_fire && (req_data.action == fbfl_pkg::ACT_ALLOC);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_idx_reg;
        wr_data = {sweep_link_valid, sweep_idx_reg - IDX_W'(1)};
        if (state_reg == S_SWEEP)
        begin
            wr_en = 1'b1;
        end
        else if (done_fire && (act_reg == fbfl_pkg::ACT_FREE) && free_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_data = {head_valid_reg, head_reg};
        end
    end

    fbfl_link_ram #(
        .DEPTH (fbfl_pkg::MAX_BLOCKS),
        .AW    (IDX_W),
        .DW    (LINK_W)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    fbfl_arith u_arith (
        .clk           (clk),
        .cmd           (arith_cmd),
        .pool_base     (pool_base_reg),
        .block_size    (eff_size),
        .block_address (req_data.block_address),
        .block_index   (head_ext[7:0]),
        .acc           (acc),
        .quotient      (quotient)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= 32'd0;
            block_size_reg  <= 13'd8;
            block_count_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fbfl_pkg::REG_POOL_BASE:
                begin
                    pool_base_reg <= cfg_data;
                end
                fbfl_pkg::REG_BLOCK_SIZE:
                begin
                    block_size_reg <= cfg_data[12:0];
                end
                fbfl_pkg::REG_BLOCK_COUNT:
                begin
                    block_count_reg <= cfg_data[8:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, free list head and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_idx_reg  <= '0;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            step_reg       <= '0;
            act_reg        <= fbfl_pkg::ACT_ALLOC;
            oom_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_SWEEP:
                begin
                    sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
                    if (sweep_idx_reg == LAST_IDX)
                    begin
                        // The rebuilt list starts at the highest block in use.
                        head_reg       <= count_m1[IDX_W-1:0];
                        head_valid_reg <= (eff_count != 9'd0);
                        state_reg      <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        act_reg <= req_data.action;
                        oom_reg <= 1'b0;
                        if (req_data.action == fbfl_pkg::ACT_FREE)
                        begin
                            step_reg  <= fbfl_pkg::DIV_TOP_STEP;
                            state_reg <= S_DIV;
                        end
                        else if (head_valid_reg)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            oom_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_MUL:
                begin
                    step_reg <= step_reg + fbfl_pkg::STEP_W'(1);
                    if (step_reg == fbfl_pkg::MUL_LAST_STEP)
                    begin
                        state_reg <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    state_reg <= S_DONE;
                end
                S_DIV:
                begin
                    step_reg <= step_reg - fbfl_pkg::STEP_W'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (done_fire)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        rsp_data_reg.granted_address <= 32'd0;
                        if (act_reg == fbfl_pkg::ACT_ALLOC)
                        begin
                            if (oom_reg)
                            begin
                                rsp_data_reg.status <= fbfl_pkg::STATUS_OOM;
                            end
                            else
                            begin
                                // Pop: the head moves to the link read at acceptance.
                                rsp_data_reg.granted_address <= acc;
                                rsp_data_reg.status          <= fbfl_pkg::STATUS_OK;
                                head_reg                     <= rd_data[IDX_W-1:0];
                                head_valid_reg               <= rd_data[IDX_W];
                            end
                        end
                        else if (free_ok)
                        begin
                            // Push: the freed block becomes the head, linking to the old one.
                            rsp_data_reg.status <= fbfl_pkg::STATUS_OK;
                            head_reg            <= free_idx;
                            head_valid_reg      <= 1'b1;
                        end
                        else
                        begin
                            rsp_data_reg.status <= fbfl_pkg::STATUS_INVALID;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Any write to a defined register restarts the rebuild of the list.
            if (cfg_hit)
            begin
                sweep_idx_reg <= '0;
                state_reg     <= S_SWEEP;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
